>>> src/pss_pkg.sv
// Package with the request modes and sequencer states of the positional sequence store.
package pss_pkg;

    localparam logic [2:0] MODE_INSERT   = 3'd0;
    localparam logic [2:0] MODE_SORTED   = 3'd1;
    localparam logic [2:0] MODE_ERASE    = 3'd2;
    localparam logic [2:0] MODE_REMOVE   = 3'd3;
    localparam logic [2:0] MODE_GET      = 3'd4;
    localparam logic [2:0] MODE_SET      = 3'd5;
    localparam logic [2:0] MODE_FIND     = 3'd6;

    localparam logic signed [7:0] INDEX_NONE = -8'sd1;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SCAN = 8'b0000_0010,
        ST_SEV  = 8'b0000_0100,
        ST_SHU  = 8'b0000_1000,
        ST_SHW  = 8'b0001_0000,
        ST_SHD  = 8'b0010_0000,
        ST_SDW  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } t_state;

endpackage

>>> src/positional_sequence_store_unit.sv
// Positional sequence store: an ordered list of up to CAPACITY items kept in one memory
// with a single read port and a single write port, walked by a small sequencer. Each
// accepted beat gives exactly one result beat, and the block takes no new beat until that
// result has been taken. Every stored item that a request touches is first read and then
// compared or written back; set and a refused insert, erase, get or set go straight to the result.
module positional_sequence_store_unit #(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_mode,
    input  logic [6:0]        i_position,
    input  logic [31:0]       i_item_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_ok,
    output logic signed [7:0] o_index_result,
    output logic [31:0]       o_read_value,
    output logic [6:0]        o_removed_count,
    output logic [6:0]        o_item_count
);
    import pss_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int YW = (CW > 8) ? CW : 8;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int VW = (ITEM_WIDTH > 32) ? ITEM_WIDTH : 32;

    logic [ITEM_WIDTH-1:0] r_mem [CAPACITY];
    logic [ITEM_WIDTH-1:0] r_rdata;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [2:0]            r_mode, n_mode;
    logic [YW-1:0]         r_idx, n_idx;
    logic [YW-1:0]         r_pos, n_pos;
    logic [YW-1:0]         r_wr, n_wr;
    logic [ITEM_WIDTH-1:0] r_val, n_val;
    logic                  r_ok, n_ok;
    logic [7:0]            r_index, n_index;
    logic [31:0]           r_rdval, n_rdval;
    logic [6:0]            r_removed, n_removed;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [ITEM_WIDTH-1:0] w_wdata;
    logic [AW-1:0]         w_raddr;

    logic [YW-1:0]         w_cnt;
    logic [YW-1:0]         w_in_pos;
    logic [YW-1:0]         w_idx_m1;
    logic [YW-1:0]         w_idx_p1;
    logic [YW-1:0]         w_rem;
    logic [VW-1:0]         w_rd_wide;
    logic                  w_full;
    logic                  w_eq;

    assign w_cnt     = YW'(r_count);
    assign w_in_pos  = YW'(i_position);
    assign w_idx_m1  = r_idx - YW'(1);
    assign w_idx_p1  = r_idx + YW'(1);
    assign w_rem     = w_cnt - r_wr;
    assign w_rd_wide = VW'(r_rdata);
    assign w_full    = (w_cnt >= YW'(CAPACITY));
    assign w_eq      = (r_rdata == r_val);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_mode    = r_mode;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_wr      = r_wr;
        n_val     = r_val;
        n_ok      = r_ok;
        n_index   = r_index;
        n_rdval   = r_rdval;
        n_removed = r_removed;
        w_we      = 1'b0;
        w_waddr   = r_idx[AW-1:0];
        w_wdata   = r_rdata;
        w_raddr   = r_idx[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_mode    = i_mode;
                    n_pos     = w_in_pos;
                    n_val     = ITEM_WIDTH'(i_item_value);
                    n_ok      = 1'b0;
                    n_index   = INDEX_NONE;
                    n_rdval   = '0;
                    n_removed = '0;
                    n_wr      = '0;
                    n_state   = ST_DONE;
                    case (i_mode)
                        MODE_INSERT: begin
                            if (!w_full && w_in_pos <= w_cnt) begin
                                n_idx   = w_cnt;
                                n_state = ST_SHU;
                            end
                        end
                        MODE_SORTED: begin
                            if (!w_full) begin
                                n_idx   = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        MODE_ERASE: begin
                            if (w_in_pos < w_cnt) begin
                                n_idx   = w_in_pos;
                                n_state = ST_SHD;
                            end
                        end
                        MODE_REMOVE, MODE_FIND: begin
                            n_idx   = '0;
                            n_state = ST_SCAN;
                        end
                        MODE_GET: begin
                            if (w_in_pos < w_cnt) begin
                                n_idx   = w_in_pos;
                                n_state = ST_SCAN;
                            end
                        end
                        MODE_SET: begin
                            if (w_in_pos < w_cnt) begin
                                w_we    = 1'b1;
                                w_waddr = w_in_pos[AW-1:0];
                                w_wdata = ITEM_WIDTH'(i_item_value);
                                n_ok    = 1'b1;
                                n_index = w_in_pos[7:0];
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_idx == w_cnt) begin
                    n_state = ST_DONE;
                    case (r_mode)
                        MODE_SORTED: begin
                            n_pos   = r_idx;
                            n_state = ST_SHU;
                        end
                        MODE_REMOVE: begin
                            n_count   = r_wr[CW-1:0];
                            n_removed = w_rem[6:0];
                            n_ok      = (w_rem != '0);
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end else begin
                    n_state = ST_SEV;
                end
            end
            ST_SEV: begin
                n_idx   = w_idx_p1;
                n_state = ST_SCAN;
                case (r_mode)
                    MODE_SORTED: begin
                        if (r_val <= r_rdata) begin
                            n_pos   = r_idx;
                            n_idx   = w_cnt;
                            n_state = ST_SHU;
                        end
                    end
                    MODE_FIND: begin
                        if (w_eq) begin
                            n_ok    = 1'b1;
                            n_index = r_idx[7:0];
                            n_idx   = r_idx;
                            n_state = ST_DONE;
                        end
                    end
                    MODE_REMOVE: begin
                        if (!w_eq) begin
                            w_we    = 1'b1;
                            w_waddr = r_wr[AW-1:0];
                            n_wr    = r_wr + YW'(1);
                        end
                    end
                    MODE_GET: begin
                        n_ok    = 1'b1;
                        n_index = r_idx[7:0];
                        n_rdval = w_rd_wide[31:0];
                        n_idx   = r_idx;
                        n_state = ST_DONE;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_SHU: begin
                if (r_idx == r_pos) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos[AW-1:0];
                    w_wdata = r_val;
                    n_count = r_count + CW'(1);
                    n_ok    = 1'b1;
                    n_index = r_pos[7:0];
                    n_state = ST_DONE;
                end else begin
                    w_raddr = w_idx_m1[AW-1:0];
                    n_state = ST_SHW;
                end
            end
            ST_SHW: begin
                w_we    = 1'b1;
                n_idx   = w_idx_m1;
                n_state = ST_SHU;
            end
            ST_SHD: begin
                if (w_idx_p1 >= w_cnt) begin
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                    n_index = r_pos[7:0];
                    n_state = ST_DONE;
                end else begin
                    w_raddr = w_idx_p1[AW-1:0];
                    n_state = ST_SDW;
                end
            end
            ST_SDW: begin
                w_we    = 1'b1;
                n_idx   = w_idx_p1;
                n_state = ST_SHD;
            end
            ST_DONE: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_wr      <= n_wr;
        r_val     <= n_val;
        r_ok      <= n_ok;
        r_index   <= n_index;
        r_rdval   <= n_rdval;
        r_removed <= n_removed;
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = (r_state == ST_DONE);
    assign o_ok            = r_ok;
    assign o_index_result  = r_index;
    assign o_read_value    = r_rdval;
    assign o_removed_count = r_removed;
    assign o_item_count    = w_cnt[6:0];

endmodule

>>> src/pss_checker.sv
// Port-level checker for the positional sequence store and its bind statement.
module pss_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_ok,
    input logic signed [7:0] o_index_result,
    input logic [31:0]       o_read_value,
    input logic [6:0]        o_removed_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Result beat dropped before it was taken.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Input taken while a request was still in flight.");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("Ready for input while a result is pending.");

    a_fail_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_index_result == -8'sd1)
        else $error("Failed request reports an index.");

    a_data_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_value != 32'd0 || o_removed_count != 7'd0) |-> o_ok)
        else $error("Read data or removed count on a failed request.");

endmodule

bind positional_sequence_store_unit pss_checker u_pss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_ok           (o_ok),
    .o_index_result (o_index_result),
    .o_read_value   (o_read_value),
    .o_removed_count(o_removed_count)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the positional sequence store with a directed table and random runs.
module tb_top;
    import pss_pkg::*;

    localparam int SEQ_DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 2 * SEQ_DEPTH + 8;
    localparam int RANDOM_ITEMS = 1525;
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    typedef struct packed {
        logic       ok;
        logic [7:0] index;
        logic [31:0] rd;
        logic [6:0] removed;
        logic [6:0] count;
    } seq_result_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [6:0]  pos;
        logic [31:0] val;
        bit          fixed;
        seq_result_t res;
    } stim_row_t;

    typedef enum int {PH_GROW, PH_CHURN, PH_SHRINK} phase_t;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_mode = '0;
    logic [6:0]  i_position = '0;
    logic [31:0] i_item_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_ok;
    logic signed [7:0] o_index_result;
    logic [31:0] o_read_value;
    logic [6:0]  o_removed_count;
    logic [6:0]  o_item_count;

    logic [31:0] model_items [SEQ_DEPTH];
    int          model_len = 0;
    seq_result_t expected_q [$];
    stim_row_t   stim_table [$];
    seq_result_t head_res;
    int          fail_count = 0;
    int          stuck_cycles = 0;
    bit          send_calm = 1'b0;
    bit          sink_calm = 1'b0;

    positional_sequence_store_unit #(
        .CAPACITY   (SEQ_DEPTH),
        .ITEM_WIDTH (32)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_position      (i_position),
        .i_item_value    (i_item_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_ok            (o_ok),
        .o_index_result  (o_index_result),
        .o_read_value    (o_read_value),
        .o_removed_count (o_removed_count),
        .o_item_count    (o_item_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void open_slot(int at, logic [31:0] v);
        int k;
        for (k = model_len; k > at; k--) begin
            model_items[k] = model_items[k - 1];
        end
        model_items[at] = v;
        model_len++;
    endfunction

    function automatic seq_result_t apply_request(logic [2:0] m, logic [6:0] p, logic [31:0] v);
        seq_result_t r;
        int k;
        int w;
        r = '0;
        r.index = INDEX_NONE;
        case (m)
            MODE_INSERT: begin
                if (model_len < SEQ_DEPTH && p <= model_len) begin
                    open_slot(p, v);
                    r.ok = 1'b1;
                    r.index = 8'(p);
                end
            end
            MODE_SORTED: begin
                k = 0;
                while (k < model_len && v > model_items[k]) k++;
                if (model_len < SEQ_DEPTH) begin
                    open_slot(k, v);
                    r.ok = 1'b1;
                    r.index = 8'(k);
                end
            end
            MODE_ERASE: begin
                if (p < model_len) begin
                    for (k = p; k + 1 < model_len; k++) begin
                        model_items[k] = model_items[k + 1];
                    end
                    model_len--;
                    r.ok = 1'b1;
                    r.index = 8'(p);
                end
            end
            MODE_REMOVE: begin
                w = 0;
                for (k = 0; k < model_len; k++) begin
                    if (model_items[k] != v) begin
                        model_items[w] = model_items[k];
                        w++;
                    end
                end
                r.removed = 7'(model_len - w);
                r.ok = (model_len != w);
                model_len = w;
            end
            MODE_GET: begin
                if (p < model_len) begin
                    r.rd = model_items[p];
                    r.ok = 1'b1;
                    r.index = 8'(p);
                end
            end
            MODE_SET: begin
                if (p < model_len) begin
                    model_items[p] = v;
                    r.ok = 1'b1;
                    r.index = 8'(p);
                end
            end
            MODE_FIND: begin
                for (k = 0; k < model_len && !r.ok; k++) begin
                    if (model_items[k] == v) begin
                        r.ok = 1'b1;
                        r.index = 8'(k);
                    end
                end
            end
            default: begin
            end
        endcase
        r.count = 7'(model_len);
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom();
            4, 5: begin
                if (model_len > 0) return model_items[$urandom_range(0, model_len - 1)];
                return 32'($urandom_range(0, 7));
            end
            default: return 32'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic void add_row(logic [2:0] m, logic [6:0] p, logic [31:0] v, bit fixed,
                                    logic ok, logic [7:0] idx, logic [31:0] rd,
                                    logic [6:0] rem, logic [6:0] cnt);
        stim_row_t row;
        row.mode = m;
        row.pos = p;
        row.val = v;
        row.fixed = fixed;
        row.res = {ok, idx, rd, rem, cnt};
        stim_table.push_back(row);
    endfunction

    task automatic send_req(input logic [2:0] m, input logic [6:0] p, input logic [31:0] v,
                            input bit fixed, input seq_result_t fixed_res);
        int gap;
        seq_result_t predicted;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_position <= p;
        i_item_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_request(m, p, v);
        expected_q.push_back(fixed ? fixed_res : predicted);
    endtask

    initial begin : stimulus
        int sent;
        int r;
        int linger;
        bit grow_next;
        phase_t phase;
        logic [2:0] m;
        logic [6:0] p;

        // Empty store: every positional access and every search must be refused.
        add_row(MODE_GET,     7'd0,   32'h0,          1, 0, INDEX_NONE, 32'h0,          0, 0);
        add_row(MODE_ERASE,   7'd0,   32'h0,          1, 0, INDEX_NONE, 32'h0,          0, 0);
        add_row(MODE_SET,     7'd0,   32'h1,          1, 0, INDEX_NONE, 32'h0,          0, 0);
        add_row(MODE_FIND,    7'd0,   32'h0,          1, 0, INDEX_NONE, 32'h0,          0, 0);
        add_row(MODE_REMOVE,  7'd0,   32'h0,          1, 0, INDEX_NONE, 32'h0,          0, 0);
        add_row(MODE_INSERT,  7'd1,   32'h0,          1, 0, INDEX_NONE, 32'h0,          0, 0);
        add_row(MODE_INSERT,  7'd0,   32'hFFFF_FFFF,  1, 1, 8'd0,       32'h0,          0, 1);
        add_row(MODE_INSERT,  7'd0,   32'h0,          1, 1, 8'd0,       32'h0,          0, 2);
        add_row(MODE_GET,     7'd1,   32'h0,          1, 1, 8'd1,       32'hFFFF_FFFF,  0, 2);
        add_row(MODE_GET,     7'd0,   32'hFFFF_FFFF,  1, 1, 8'd0,       32'h0,          0, 2);
        add_row(MODE_INSERT,  7'd2,   32'h5555_5555,  0, 0, 0, 0, 0, 0);
        add_row(MODE_SORTED,  7'd0,   32'hAAAA_AAAA,  0, 0, 0, 0, 0, 0);
        add_row(MODE_SORTED,  7'd127, 32'h0,          0, 0, 0, 0, 0, 0);
        add_row(MODE_SORTED,  7'd0,   32'hFFFF_FFFF,  0, 0, 0, 0, 0, 0);
        add_row(MODE_SET,     7'd127, 32'h1,          1, 0, INDEX_NONE, 32'h0,          0, 6);
        add_row(MODE_GET,     7'd6,   32'h0,          1, 0, INDEX_NONE, 32'h0,          0, 6);
        add_row(MODE_SET,     7'd2,   32'h1234_5678,  0, 0, 0, 0, 0, 0);
        add_row(MODE_FIND,    7'd0,   32'hFFFF_FFFF,  0, 0, 0, 0, 0, 0);
        add_row(MODE_FIND,    7'd0,   32'hDEAD_BEEF,  1, 0, INDEX_NONE, 32'h0,          0, 6);
        add_row(MODE_UNUSED,  7'd0,   32'h0,          1, 0, INDEX_NONE, 32'h0,          0, 6);
        add_row(MODE_REMOVE,  7'd0,   32'h0,          0, 0, 0, 0, 0, 0);
        add_row(MODE_ERASE,   7'd0,   32'h0,          0, 0, 0, 0, 0, 0);
        add_row(MODE_ERASE,   7'd127, 32'h0,          1, 0, INDEX_NONE, 32'h0,          0, 3);
        add_row(MODE_INSERT,  7'd127, 32'h7,          1, 0, INDEX_NONE, 32'h0,          0, 3);
        add_row(MODE_INSERT,  7'd3,   32'h0F0F_0F0F,  0, 0, 0, 0, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            send_req(stim_table[i].mode, stim_table[i].pos, stim_table[i].val,
                     stim_table[i].fixed, stim_table[i].res);
        end

        // Alternate filling to capacity, mixed traffic and draining to empty.
        sent = 0;
        phase = PH_GROW;
        grow_next = 1'b0;
        linger = $urandom_range(3, 20);
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            case (phase)
                PH_GROW: m = r < 35 ? MODE_INSERT : r < 70 ? MODE_SORTED : r < 78 ? MODE_GET :
                             r < 84 ? MODE_SET : r < 94 ? MODE_FIND : MODE_ERASE;
                PH_SHRINK: m = r < 40 ? MODE_ERASE : r < 60 ? MODE_REMOVE : r < 70 ? MODE_GET :
                               r < 80 ? MODE_FIND : r < 90 ? MODE_INSERT : MODE_SORTED;
                default: m = (r < 2) ? MODE_UNUSED : 3'($urandom_range(0, 6));
            endcase
            if ($urandom_range(0, 9) == 0) p = 7'($urandom_range(0, 127));
            else p = 7'($urandom_range(0, model_len));
            send_req(m, p, pick_value(), 1'b0, '0);
            if (m != MODE_UNUSED) sent++;

            if (phase == PH_CHURN || (phase == PH_GROW && model_len == SEQ_DEPTH) ||
                (phase == PH_SHRINK && model_len == 0)) begin
                linger--;
            end
            if (linger <= 0) begin
                if (phase != PH_CHURN) begin
                    phase = PH_CHURN;
                    linger = $urandom_range(40, 150);
                end else begin
                    phase = grow_next ? PH_GROW : PH_SHRINK;
                    grow_next = !grow_next;
                    linger = $urandom_range(3, 20);
                end
            end
        end
        i_in_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin : result_sink
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
            stall = sink_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: result beat expected none, got ok %b index %0d count %0d",
                         $time, o_ok, o_index_result, o_item_count);
                fail_count++;
            end else begin
                head_res = expected_q.pop_front();
                check_field("ok", 32'(head_res.ok), 32'(o_ok));
                check_field("index_result", 32'(head_res.index), 32'(unsigned'(o_index_result)));
                check_field("read_value", head_res.rd, o_read_value);
                check_field("removed_count", 32'(head_res.removed), 32'(o_removed_count));
                check_field("item_count", 32'(head_res.count), 32'(o_item_count));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

endmodule
